/* rtl/rlsd_pkg.sv */
// shared types and constants for the led matrix scan driver
// no dependencies; imported by every rtl module of the block
package rlsd_pkg;

	localparam int ROWS       = 8;
	localparam int COLS       = 8;
	localparam int GROUP_BITS = 8;

	localparam int ROW_W   = $clog2(ROWS);
	localparam int COL_W   = $clog2(COLS);
	localparam int ADDR_W  = $clog2(ROWS * COLS);
	localparam int DEPTH   = ROWS * COLS;
	localparam int CLR_W   = 3;
	localparam int IDX_W   = $clog2(GROUP_BITS);
	localparam int CNT_W   = IDX_W + 1;
	localparam int POS_W   = 5;

	localparam logic [CNT_W-1:0] LAST_BLANK = CNT_W'(GROUP_BITS - 1);
	localparam logic [CNT_W-1:0] LAST_LIT   = CNT_W'(2 * GROUP_BITS - 1);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// one scan tick on its way to the serializer
	typedef struct packed {
		logic [CLR_W-1:0] color;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} tick_t;

endpackage

/* rtl/rlsd_frame_mem.sv */
// frame buffer: one-write one-read memory with registered read data
// per-entry valid bits make the whole frame read as dark after reset; uses rlsd_pkg
module rlsd_frame_mem
	import rlsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [CLR_W-1:0]  wr_color,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [CLR_W-1:0]  rd_color
);

	logic [CLR_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [CLR_W-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_color;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	// never written entry reads as black
	assign rd_color = rd_vld_q ? rd_data_q : '0;

endmodule

/* rtl/rlsd_serializer.sv */
// bit serializer: turns one scan tick into a blanking group and, for a lit
// pixel, an active-low select group; registered output word; uses rlsd_pkg
module rlsd_serializer
	import rlsd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load_valid,
	output logic  load_ready,
	input  tick_t load_tick,
	output logic  row_bit,
	output logic  red_bit,
	output logic  green_bit,
	output logic  blue_bit,
	output logic  group_end,
	output logic  last,
	output logic  valid,
	input  logic  stall
);

	logic             active_q;
	tick_t            tick_q;
	logic [CNT_W-1:0] cnt_q;

	logic             adv;
	logic             fin;
	logic             lit_grp;
	logic [IDX_W-1:0] idx;
	logic [POS_W-1:0] pos;
	logic             at_row;
	logic             at_col;
	logic             nx_row, nx_red, nx_green, nx_blue, nx_end, nx_last;

	assign adv     = active_q && (!valid || !stall);
	assign fin     = (cnt_q == LAST_LIT) || ((cnt_q == LAST_BLANK) && (tick_q.color == '0));
	assign load_ready = !active_q || (adv && fin);
	assign lit_grp = cnt_q[IDX_W];
	assign idx     = cnt_q[IDX_W-1:0];
	assign pos     = POS_W'(GROUP_BITS - 1) - POS_W'(idx);
	assign at_row  = (pos == POS_W'(tick_q.row));
	assign at_col  = (pos == POS_W'(tick_q.col));

	always_comb begin
		nx_end   = (idx == IDX_W'(GROUP_BITS - 1));
		nx_last  = fin;
		if (lit_grp) begin
			nx_row   = !at_row;
			nx_red   = !(at_col && tick_q.color[0]);
			nx_green = !(at_col && tick_q.color[1]);
			nx_blue  = !(at_col && tick_q.color[2]);
		end else begin
			nx_row   = 1'b1;
			nx_red   = 1'b1;
			nx_green = 1'b1;
			nx_blue  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			valid    <= 1'b0;
		end else begin
			if (load_valid && load_ready) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (adv) begin
				if (fin) begin
					active_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			if (adv) begin
				valid <= 1'b1;
			end else if (!stall) begin
				valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			tick_q <= load_tick;
		end
		if (adv) begin
			row_bit   <= nx_row;
			red_bit   <= nx_red;
			green_bit <= nx_green;
			blue_bit  <= nx_blue;
			group_end <= nx_end;
			last      <= nx_last;
		end
	end

endmodule

/* rtl/rgb_led_matrix_scan_driver.sv */
// rgb led matrix scan driver top level
// uses rlsd_pkg, rlsd_frame_mem and rlsd_serializer
//
// input channel (item_valid / item_stall): one word per item; func selects a
// pixel write (row, col, 3-bit color, bit0 red bit1 green bit2 blue) or a
// scan tick. a write produces nothing. a tick advances
// the scan position in row-major order, wrapping at the end of the frame.
// output channel (bit_valid / bit_stall): one word per serial shift bit,
// carrying the row, red, green and blue data lines plus group_end and last.
// a tick gives 8 words (all high blanking) when its pixel is dark, else 16
// words (blanking, then the active-low select group, msb first).
// the first word of a tick passes the frame read at the accepting edge,
// then the serializer load, which waits while the serializer is busy,
// then the output register. the serializer puts out one output word per
// clock while bit_stall is low; the next tick is read from the frame
// while the current one shifts, and shifting continues back to back
// across ticks. writes are accepted every cycle unless a read-out tick
// is waiting for the serializer.
// reset clears the frame (per-entry valid bits, no clearing pass) and sets
// the scan position to the last pixel, so the first tick scans (0,0).
// when bit_stall is high the output word holds and the serializer pauses;
// the stall reaches item_stall once a tick is waiting behind it.
module rgb_led_matrix_scan_driver
	import rlsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       func,
	input  logic [2:0] pixel_row,
	input  logic [2:0] pixel_col,
	input  logic [2:0] pixel_color,
	output logic       bit_valid,
	input  logic       bit_stall,
	output logic       row_bit,
	output logic       red_bit,
	output logic       green_bit,
	output logic       blue_bit,
	output logic       group_end,
	output logic       last
);

	// scan position of the most recent tick
	logic [ROW_W-1:0] scan_row_q;
	logic [COL_W-1:0] scan_col_q;
	logic [ROW_W-1:0] nxt_row;
	logic [COL_W-1:0] nxt_col;

	// tick whose frame read is in flight or waiting for the serializer
	logic             tick_vld_s1;
	logic [ROW_W-1:0] tick_row_s1;
	logic [COL_W-1:0] tick_col_s1;

	logic              accept;
	logic              wr_en;
	logic              rd_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [CLR_W-1:0]  rd_color;
	logic              ser_ready;
	tick_t             ser_tick;

	assign item_stall = tick_vld_s1 && !ser_ready;
	assign accept     = item_valid && !item_stall;

	// writes outside the frame are dropped
	assign wr_en = accept && (func == FUNC_WRITE) && (pixel_row < ROWS) && (pixel_col < COLS);
	assign rd_en = accept && (func == FUNC_TICK);

	// next scan position, row-major with wrap
	always_comb begin
		if (scan_col_q == COL_W'(COLS - 1)) begin
			nxt_col = '0;
			nxt_row = (scan_row_q == ROW_W'(ROWS - 1)) ? '0 : scan_row_q + 1'b1;
		end else begin
			nxt_col = scan_col_q + 1'b1;
			nxt_row = scan_row_q;
		end
	end

	assign wr_addr = ADDR_W'(ADDR_W'(pixel_row) * ADDR_W'(COLS) + ADDR_W'(pixel_col));
	assign rd_addr = ADDR_W'(ADDR_W'(nxt_row) * ADDR_W'(COLS) + ADDR_W'(nxt_col));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q  <= ROW_W'(ROWS - 1);
			scan_col_q  <= COL_W'(COLS - 1);
			tick_vld_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				scan_row_q <= nxt_row;
				scan_col_q <= nxt_col;
			end
			// a waiting tick leaves when the serializer takes it
			if (rd_en) begin
				tick_vld_s1 <= 1'b1;
			end else if (ser_ready) begin
				tick_vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			tick_row_s1 <= nxt_row;
			tick_col_s1 <= nxt_col;
		end
	end

	rlsd_frame_mem u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_color (pixel_color),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_color (rd_color)
	);

	// read data stays put while the tick waits: no new read until it leaves
	assign ser_tick.color = rd_color;
	assign ser_tick.row   = tick_row_s1;
	assign ser_tick.col   = tick_col_s1;

	rlsd_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (tick_vld_s1),
		.load_ready (ser_ready),
		.load_tick  (ser_tick),
		.row_bit    (row_bit),
		.red_bit    (red_bit),
		.green_bit  (green_bit),
		.blue_bit   (blue_bit),
		.group_end  (group_end),
		.last       (last),
		.valid      (bit_valid),
		.stall      (bit_stall)
	);

endmodule

/* sim/rlsd_scan_checker.sv */
// checker for the led matrix scan driver: predicts the serial shift words
// of every accepted tick and compares them with the output channel
// depends on rlsd_pkg for sizes and the func codes
module rlsd_scan_checker
	import rlsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_stall,
	input  logic       func,
	input  logic [2:0] pixel_row,
	input  logic [2:0] pixel_col,
	input  logic [2:0] pixel_color,
	input  logic       bit_valid,
	input  logic       bit_stall,
	input  logic       row_bit,
	input  logic       red_bit,
	input  logic       green_bit,
	input  logic       blue_bit,
	input  logic       group_end,
	input  logic       last,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic row;
		logic red;
		logic green;
		logic blue;
		logic gend;
		logic last;
	} shift_word_t;

	logic [CLR_W-1:0] frame_copy [DEPTH];
	logic [ROW_W-1:0] scan_r;
	logic [COL_W-1:0] scan_c;
	shift_word_t      shift_words[$];
	shift_word_t      want;

	// step the scan position and queue the blanking and select groups
	task automatic predict_tick();
		logic [CLR_W-1:0] color;
		int               pos;
		if (scan_c == COL_W'(COLS - 1)) begin
			scan_c = '0;
			scan_r = (scan_r == ROW_W'(ROWS - 1)) ? '0 : scan_r + 1'b1;
		end else begin
			scan_c = scan_c + 1'b1;
		end
		color = frame_copy[int'(scan_r) * COLS + int'(scan_c)];
		for (int i = 0; i < GROUP_BITS; i++) begin
			shift_words.push_back('{1'b1, 1'b1, 1'b1, 1'b1, i == GROUP_BITS - 1,
				(color == '0) && (i == GROUP_BITS - 1)});
		end
		if (color != '0) begin
			for (int i = 0; i < GROUP_BITS; i++) begin
				pos = GROUP_BITS - 1 - i;
				shift_words.push_back('{pos != int'(scan_r),
					!(pos == int'(scan_c) && color[0]),
					!(pos == int'(scan_c) && color[1]),
					!(pos == int'(scan_c) && color[2]),
					i == GROUP_BITS - 1, i == GROUP_BITS - 1});
			end
		end
	endtask

	task automatic check_field(string name, logic exp_val, logic act_val);
		if (exp_val !== act_val) begin
			$error("%s mismatch: expected %0b, got %0b", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (frame_copy[i]) frame_copy[i] = '0;
			scan_r = ROW_W'(ROWS - 1);
			scan_c = COL_W'(COLS - 1);
			shift_words.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (bit_valid && !bit_stall) begin
				if (shift_words.size() == 0) begin
					$error("shift word with none expected: row %0b red %0b green %0b blue %0b",
						row_bit, red_bit, green_bit, blue_bit);
					fail_count++;
				end else begin
					want = shift_words.pop_front();
					check_field("row_bit", want.row, row_bit);
					check_field("red_bit", want.red, red_bit);
					check_field("green_bit", want.green, green_bit);
					check_field("blue_bit", want.blue, blue_bit);
					check_field("group_end", want.gend, group_end);
					check_field("last", want.last, last);
				end
			end
			if (item_valid && !item_stall) begin
				if (func == FUNC_TICK) begin
					predict_tick();
				end else if (int'(pixel_row) < ROWS && int'(pixel_col) < COLS) begin
					frame_copy[int'(pixel_row) * COLS + int'(pixel_col)] = pixel_color;
				end
			end
			pending <= shift_words.size();
		end
	end

endmodule

/* sim/testbench.sv */
// top of the scan driver testbench: clock, reset, pixel writes and ticks
// depends on rlsd_pkg, rgb_led_matrix_scan_driver and rlsd_scan_checker
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rlsd_pkg::*;

	// far above the slowest correct run
	localparam int CYCLE_LIMIT  = 100000;
	localparam int RANDOM_ITEMS = 400;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       item_valid  = 1'b0;
	logic       item_stall;
	logic       func        = FUNC_WRITE;
	logic [2:0] pixel_row   = '0;
	logic [2:0] pixel_col   = '0;
	logic [2:0] pixel_color = '0;
	logic       bit_valid;
	logic       bit_stall   = 1'b0;
	logic       row_bit;
	logic       red_bit;
	logic       green_bit;
	logic       blue_bit;
	logic       group_end;
	logic       last;
	int         fail_count;
	int         pending;
	int         cycle_count = 0;
	// no idling on either side while set
	logic       calm        = 1'b0;

	always #2 clk = ~clk;

	rgb_led_matrix_scan_driver u_top (.*);

	rlsd_scan_checker u_checker (.*);

	// receiver holds off about a fifth of the cycles unless calm
	always @(posedge clk) begin
		bit_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 21);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// present one word, with random idle cycles first, and wait for acceptance
	task automatic send_word(logic f, logic [2:0] r, logic [2:0] c, logic [2:0] color);
		while (!calm && $urandom_range(0, 99) < 21) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid  <= 1'b1;
		func        <= f;
		pixel_row   <= r;
		pixel_col   <= c;
		pixel_color <= color;
		do @(posedge clk); while (item_stall);
	endtask

	// hold the sender until every predicted shift word has come out
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [2:0] color;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first tick lands on (0,0), still dark after reset: blanking only
		send_word(FUNC_TICK, 3'd0, 3'd0, 3'd0);
		// white pixel, then each single primary on the following columns
		send_word(FUNC_WRITE, 3'd0, 3'd1, 3'd7);
		send_word(FUNC_TICK, 3'd7, 3'd7, 3'd7);
		send_word(FUNC_WRITE, 3'd0, 3'd2, 3'd1);
		send_word(FUNC_TICK, 3'd0, 3'd0, 3'd0);
		send_word(FUNC_WRITE, 3'd0, 3'd3, 3'd2);
		send_word(FUNC_TICK, 3'd0, 3'd0, 3'd0);
		send_word(FUNC_WRITE, 3'd0, 3'd4, 3'd4);
		send_word(FUNC_TICK, 3'd0, 3'd0, 3'd0);
		// lit pixel overwritten with black goes back to a dark tick
		send_word(FUNC_WRITE, 3'd0, 3'd5, 3'd6);
		send_word(FUNC_WRITE, 3'd0, 3'd5, 3'd0);
		send_word(FUNC_TICK, 3'd0, 3'd0, 3'd0);
		send_word(FUNC_WRITE, 3'd0, 3'd6, 3'd3);
		send_word(FUNC_WRITE, 3'd0, 3'd7, 3'd5);
		send_word(FUNC_TICK, 3'd0, 3'd0, 3'd0);
		// last column of row 0, then the wrap to the next row
		send_word(FUNC_TICK, 3'd0, 3'd0, 3'd0);
		send_word(FUNC_WRITE, 3'd1, 3'd0, 3'd6);
		send_word(FUNC_TICK, 3'd0, 3'd0, 3'd0);
		// far corner, reached later when the scan wraps the frame
		send_word(FUNC_WRITE, 3'd7, 3'd7, 3'd7);
		send_word(FUNC_WRITE, 3'd7, 3'd0, 3'd1);
		drain();

		// random mix: a bit more ticks than writes, mostly lit colors
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 120) drain();
			if (n == 200) calm <= 1'b1;
			if (n == 290) calm <= 1'b0;
			if ($urandom_range(0, 99) < 55) begin
				// payload on a tick is ignored, randomize it anyway
				send_word(FUNC_TICK, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					3'($urandom_range(0, 7)));
			end else begin
				color = ($urandom_range(0, 99) < 15) ? 3'd0 : 3'($urandom_range(1, 7));
				send_word(FUNC_WRITE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					color);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/rlsd_pkg.sv
rtl/rlsd_frame_mem.sv
rtl/rlsd_serializer.sv
rtl/rgb_led_matrix_scan_driver.sv
sim/rlsd_scan_checker.sv
sim/testbench.sv
